[sv/i2a_pkg.sv]
// shared constants, types and the digit-to-character function for the radix converter
`default_nettype none

package i2a_pkg;

	// defaults for the top-level parameters
	localparam int VALUE_BITS_DEF = 64;
	localparam int MAX_RADIX_DEF  = 36;

	// fixed field widths
	localparam int VALUE_W = 64;
	localparam int RADIX_W = 6;
	localparam int CHAR_W  = 8;

	// radix register reset and the special radix values
	localparam logic [RADIX_W-1:0] RADIX_RST = 6'd10;
	localparam logic [RADIX_W-1:0] MIN_RADIX = 6'd2;
	localparam logic [RADIX_W-1:0] DEC_RADIX = 6'd10;

	// character codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] TEN      = 8'd10;

	// control from the sequencer to the digit row
	typedef struct packed {
		logic clr;
		logic feed;
		logic bit_in;
		logic shift;
	} row_ctl_t;

	// digit value to lower-case ascii
	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {2'b00, d};
		if (dx < TEN) begin
			return CH_ZERO + dx;
		end else begin
			return CH_LA + dx - TEN;
		end
	endfunction

endpackage

`default_nettype wire

[sv/i2a_digit_row.sv]
// row of radix digit cells: shift-in doubling with a skewed carry wave, then shift-out
`default_nettype none

module i2a_digit_row #(
	parameter int NCELLS = 64,
	parameter int DIG_W  = 6,
	parameter int RDX_W  = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire i2a_pkg::row_ctl_t ctl,
	input  wire logic [RDX_W-1:0]  radix,
	output logic      [DIG_W-1:0]  top_digit
);
	import i2a_pkg::*;

	logic [DIG_W-1:0] dig_q [NCELLS];
	logic [NCELLS-1:0] cy_q;
	logic [NCELLS-1:0] vl_q;
	logic [NCELLS-1:0] cin_v;
	logic [NCELLS-1:0] cin_b;
	logic [NCELLS-1:0] cout;
	logic [DIG_W-1:0] dig_nxt [NCELLS];
	logic [DIG_W-1:0] dig_below [NCELLS];

	genvar i;
	generate
		for (i = 0; i < NCELLS; i++) begin : g_cell
			logic [DIG_W:0] dbl;
			logic           ge;
			logic [DIG_W:0] red;

			// carry and valid come from the input for the first cell, else from below
			if (i == 0) begin : g_first
				assign cin_v[i]     = ctl.feed;
				assign cin_b[i]     = ctl.bit_in;
				assign dig_below[i] = '0;
			end else begin : g_next
				assign cin_v[i]     = vl_q[i-1];
				assign cin_b[i]     = cy_q[i-1];
				assign dig_below[i] = dig_q[i-1];
			end

			// digit times two plus carry, reduced once by the radix
			assign dbl        = {dig_q[i], cin_b[i]};
			assign ge         = (dbl >= radix);
			assign red        = ge ? (dbl - radix) : dbl;
			assign dig_nxt[i] = red[DIG_W-1:0];
			assign cout[i]    = ge;

			// digit storage: clear, shift toward the top, or update on the wave
			always_ff @(posedge clk) begin
				if (ctl.clr) begin
					dig_q[i] <= '0;
				end else if (ctl.shift) begin
					dig_q[i] <= dig_below[i];
				end else if (cin_v[i]) begin
					dig_q[i] <= dig_nxt[i];
				end
			end
		end
	endgenerate

	// carry wave registers between neighbor cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cy_q <= '0;
			vl_q <= '0;
		end else if (ctl.clr) begin
			cy_q <= '0;
			vl_q <= '0;
		end else begin
			cy_q <= cout & cin_v;
			vl_q <= cin_v;
		end
	end

	assign top_digit = dig_q[NCELLS-1];

`ifndef ASSERT_OFF
	// the row is never loaded and unloaded in the same cycle
	a_no_feed_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.feed && ctl.shift))
		else $error("digit row fed while shifting out");

	// the wave never carries out of the top cell
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(vl_q[NCELLS-1] && cy_q[NCELLS-1]))
		else $error("digit row overflow");

	// nothing is still moving in the row when digits start shifting out
	a_quiet_on_shift: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift |-> (vl_q == '0))
		else $error("digit row shifted during conversion");
`endif

endmodule

`default_nettype wire

[sv/int64_to_ascii_radix.sv]
// integer to ascii converter in a programmable radix, top level
//
// Usage: write the radix (2 to MAX_RADIX) on cfg_wdata with cfg_we while the
// block is idle; it resets to 10. Each request on the input channel carries
// action (0 signed, 1 unsigned) and value. The block answers with a string of
// character requests on the output channel, most significant digit first, with
// last set on the final one. A signed request in radix 10 with a negative
// value starts with '-'. An invalid radix gives one request with out_char 0,
// last 1 and error 1.
// Timing: the input is taken only when the converter is idle. The value bits
// enter a row of VALUE_BITS digit cells one per cycle while the carry wave
// climbs toward the top cell. Leading zero digits are then dropped one per
// cycle and the characters leave one per cycle unless the receiver stalls.
// Reset clears the sequencer and the output valid flag and sets radix to 10.
// A stall on out_ready holds the current character and holds the sequencer
// in its sign, digit and error states.
`default_nettype none

module int64_to_ascii_radix #(
	parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF,
	parameter int MAX_RADIX  = i2a_pkg::MAX_RADIX_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [i2a_pkg::RADIX_W-1:0]  cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         action,
	input  wire logic [i2a_pkg::VALUE_W-1:0]  value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [i2a_pkg::CHAR_W-1:0]   out_char,
	output logic                              last,
	output logic                              error
);
	import i2a_pkg::*;

	localparam int NCELLS = VALUE_BITS;
	localparam int DIG_W  = $clog2(MAX_RADIX);
	localparam int RDX_W  = DIG_W + 1;
	localparam int CNT_W  = $clog2(VALUE_BITS + NCELLS + 1);
	localparam int REM_W  = $clog2(NCELLS + 1);
	localparam logic [CNT_W-1:0] CNT_FEED = CNT_W'(VALUE_BITS);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(VALUE_BITS + NCELLS - 1);
	localparam logic [REM_W-1:0] REM_ALL  = REM_W'(NCELLS);
	localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CONV = 6'b000010,
		ST_SKIP = 6'b000100,
		ST_SIGN = 6'b001000,
		ST_EMIT = 6'b010000,
		ST_ERR  = 6'b100000
	} state_t;

	state_t              state_q;
	state_t              state_d;
	logic [RADIX_W-1:0]  radix_q;
	logic [VALUE_BITS-1:0] sreg_q;
	logic                neg_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [REM_W-1:0]    rem_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                last_q;
	logic                error_q;

	logic                acc;
	logic                rdx_ok;
	logic                neg_in;
	logic [VALUE_BITS-1:0] v_in;
	logic [VALUE_BITS-1:0] mag;
	logic                out_free;
	logic [DIG_W-1:0]    top_digit;
	logic [RDX_W-1:0]    row_radix;
	row_ctl_t            row_ctl;
	logic                ld;
	logic [CHAR_W-1:0]   ld_char;
	logic                ld_last;
	logic                ld_err;

	// radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RST;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// input decode: radix check, sign and magnitude
	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign rdx_ok    = (radix_q >= MIN_RADIX) && (radix_q <= RADIX_W'(MAX_RADIX));
	assign v_in      = value[VALUE_BITS-1:0];
	assign neg_in    = !action && (radix_q == DEC_RADIX) && v_in[VALUE_BITS-1];
	assign mag       = neg_in ? (~v_in + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v_in;
	assign row_radix = RDX_W'(radix_q);
	assign out_free  = !out_valid_q || out_ready;

	// sequencer
	always_comb begin
		state_d = state_q;
		row_ctl = '0;
		ld      = 1'b0;
		ld_char = CH_NUL;
		ld_last = 1'b0;
		ld_err  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					row_ctl.clr = 1'b1;
					state_d     = rdx_ok ? ST_CONV : ST_ERR;
				end
			end
			ST_CONV: begin
				if (cnt_q < CNT_FEED) begin
					row_ctl.feed   = 1'b1;
					row_ctl.bit_in = sreg_q[VALUE_BITS-1];
				end
				if (cnt_q == CNT_END) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if ((top_digit == '0) && (rem_q > REM_ONE)) begin
					row_ctl.shift = 1'b1;
				end else begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_char = CH_MINUS;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					ld            = 1'b1;
					ld_char       = digit_char(RADIX_W'(top_digit));
					ld_last       = (rem_q == REM_ONE);
					row_ctl.shift = 1'b1;
					if (rem_q == REM_ONE) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_char = CH_NUL;
					ld_last = 1'b1;
					ld_err  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				cnt_q <= '0;
				rem_q <= REM_ALL;
				neg_q <= neg_in;
			end else begin
				if (state_q == ST_CONV) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (row_ctl.shift) begin
					rem_q <= rem_q - 1'b1;
				end
			end
		end
	end

	// value shift register, msb first
	always_ff @(posedge clk) begin
		if (acc) begin
			sreg_q <= mag;
		end else if (row_ctl.feed) begin
			sreg_q <= {sreg_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_char_q <= ld_char;
			last_q     <= ld_last;
			error_q    <= ld_err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;
	assign error     = error_q;

	i2a_digit_row #(
		.NCELLS (NCELLS),
		.DIG_W  (DIG_W),
		.RDX_W  (RDX_W)
	) u_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (row_ctl),
		.radix     (row_radix),
		.top_digit (top_digit)
	);

`ifndef ASSERT_OFF
	// an error request is a lone nul character
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && error_q) |-> (last_q && (out_char_q == CH_NUL)))
		else $error("malformed error request");

	// a minus sign never ends a string
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q && !error_q) |-> (out_char_q != CH_MINUS))
		else $error("string ends in a minus sign");

	// skipping leading zeros always keeps at least one digit
	a_keep_digit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SKIP) || (state_q == ST_EMIT)) |-> (rem_q != '0))
		else $error("digit count ran out");

	// the last digit returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && ld_last) |=> (state_q == ST_IDLE))
		else $error("sequencer busy after last character");
`endif

endmodule

`default_nettype wire
